// ===== src/dnsmfp_pkg.sv =====
// ----------------------------------------------------------------------------
// dnsmfp_pkg
// Shared types and constants of the DNS message field parser.
// ----------------------------------------------------------------------------
package dnsmfp_pkg;

  localparam int PACKET_BYTES  = 2048;
  localparam int MAX_QUESTIONS = 32;
  localparam int MAX_ANSWERS   = 32;

  localparam int OFS_W    = 11;
  localparam int OFS_MAX  = (PACKET_BYTES - 1 < 2047) ? PACKET_BYTES - 1 : 2047;
  localparam int QCNT_W   = $clog2(MAX_QUESTIONS + 1);
  localparam int ACNT_W   = $clog2(MAX_ANSWERS + 1);

  localparam int HDR_BYTES   = 12;
  localparam int HDR_SHIFTED = 8;
  localparam int TC_BYTES    = 4;
  localparam int TTL_BYTES   = 4;
  localparam int RDLEN_BYTES = 2;

  localparam logic [7:0] PTR_MASK = 8'hc0;

  localparam int TDATA_W = 184;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_NAME,
    PH_PTR2,
    PH_TYPECLASS,
    PH_TTL,
    PH_RDLEN,
    PH_RDATA,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    KIND_HEADER   = 3'd0,
    KIND_QUESTION = 3'd1,
    KIND_ANSWER   = 3'd2,
    KIND_SHORT    = 3'd3,
    KIND_TRUNC    = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t              result_kind;
    logic [15:0]        query_id;
    logic [15:0]        header_flags;
    logic [15:0]        question_count;
    logic [15:0]        answer_count;
    logic [OFS_W-1:0]   name_offset;
    logic [10:0]        name_length;
    logic [15:0]        record_type;
    logic [15:0]        record_class;
    logic [31:0]        time_to_live;
    logic [OFS_W-1:0]   rdata_offset;
    logic [15:0]        rdata_length;
  } res_t;

endpackage

// ===== src/dnsmfp_core.sv =====
// ----------------------------------------------------------------------------
// dnsmfp_core
// Per-byte parse state machine; produces at most one result per accepted byte.
// ----------------------------------------------------------------------------
module dnsmfp_core import dnsmfp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic [7:0] packet_byte,
  input  logic       last_byte,
  output logic       res_valid,
  output res_t       res
);

  phase_t              phase_r, phase_nxt;
  logic [OFS_W-1:0]    byte_offset_r, byte_offset_nxt;
  logic [63:0]         header_shift_r, header_shift_nxt;
  logic [QCNT_W-1:0]   questions_left_r, questions_left_nxt;
  logic [ACNT_W-1:0]   answers_left_r, answers_left_nxt;
  logic [2:0]          field_position_r, field_position_nxt;
  logic [7:0]          label_skip_left_r, label_skip_left_nxt;
  logic [OFS_W-1:0]    record_start_r, record_start_nxt;
  logic [63:0]         tc_shift_r, tc_shift_nxt;
  logic [15:0]         rdata_skip_left_r, rdata_skip_left_nxt;
  logic [OFS_W-1:0]    rdata_start_r, rdata_start_nxt;
  logic [15:0]         saved_rdata_length_r, saved_rdata_length_nxt;
  logic [10:0]         name_bytes_r, name_bytes_nxt;

  logic [OFS_W-1:0]    cur, off_inc;
  logic                skip_zero, name_first, name_end, name_ptr;
  logic                tc_done, ttl_done, rdlen_done, q_emit, a_emit, hdr_emit;
  logic                in_record, trunc;
  logic [15:0]         rdlen_val, hdr_qd, hdr_an;
  logic [QCNT_W-1:0]   qd_clamp;
  logic [ACNT_W-1:0]   an_clamp;
  logic                more_hdr, more_q, more_a;
  logic [63:0]         tc_shifted;
  logic [10:0]         name_bytes_inc;

  assign cur     = byte_offset_r;
  assign off_inc = (cur < OFS_W'(OFS_MAX)) ? cur + OFS_W'(1) : OFS_W'(OFS_MAX);

  assign skip_zero  = (label_skip_left_r == 8'd0);
  assign name_first = (phase_r == PH_NAME) && (field_position_r == 3'd0);
  assign name_end   = (phase_r == PH_NAME) && skip_zero && (packet_byte == 8'd0);
  assign name_ptr   = (phase_r == PH_NAME) && skip_zero && (packet_byte != 8'd0) &&
                      ((packet_byte & PTR_MASK) != 8'd0);

  assign tc_done    = (phase_r == PH_TYPECLASS) && (field_position_r == 3'(TC_BYTES - 1));
  assign ttl_done   = (phase_r == PH_TTL) && (field_position_r == 3'(TTL_BYTES - 1));
  assign rdlen_done = (phase_r == PH_RDLEN) && (field_position_r == 3'(RDLEN_BYTES - 1));
  assign rdlen_val  = {saved_rdata_length_r[7:0], packet_byte};
  assign q_emit     = tc_done && (questions_left_r != '0);
  assign a_emit     = (rdlen_done && (rdlen_val == 16'd0)) ||
                      ((phase_r == PH_RDATA) && (rdata_skip_left_r == 16'd1));
  assign hdr_emit   = (phase_r == PH_HEADER) && (cur >= OFS_W'(HDR_BYTES - 1));

  assign hdr_qd   = header_shift_r[31:16];
  assign hdr_an   = header_shift_r[15:0];
  assign qd_clamp = (hdr_qd < 16'(MAX_QUESTIONS)) ? hdr_qd[QCNT_W-1:0] : QCNT_W'(MAX_QUESTIONS);
  assign an_clamp = (hdr_an < 16'(MAX_ANSWERS)) ? hdr_an[ACNT_W-1:0] : ACNT_W'(MAX_ANSWERS);

  assign more_hdr = (qd_clamp != '0) || (an_clamp != '0);
  assign more_q   = (questions_left_r > QCNT_W'(1)) || (answers_left_r != '0);
  assign more_a   = (answers_left_r > ACNT_W'(1)) || (questions_left_r != '0);

  assign in_record = (phase_r != PH_HEADER) && (phase_r != PH_DONE);
  assign trunc     = last_byte && in_record && !(q_emit || a_emit);

  assign tc_shifted     = {tc_shift_r[55:0], packet_byte};
  assign name_bytes_inc = (name_bytes_r != '1) ? name_bytes_r + 11'd1 : name_bytes_r;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (in_fire) begin
      if (last_byte) begin
        phase_nxt = PH_HEADER;
      end else begin
        unique case (phase_r)
          PH_HEADER: begin
            if (hdr_emit) phase_nxt = more_hdr ? PH_NAME : PH_DONE;
          end
          PH_NAME: begin
            if (name_end) phase_nxt = PH_TYPECLASS;
            else if (name_ptr) phase_nxt = PH_PTR2;
          end
          PH_PTR2: phase_nxt = PH_TYPECLASS;
          PH_TYPECLASS: begin
            if (tc_done) begin
              if (q_emit) phase_nxt = more_q ? PH_NAME : PH_DONE;
              else phase_nxt = PH_TTL;
            end
          end
          PH_TTL: begin
            if (ttl_done) phase_nxt = PH_RDLEN;
          end
          PH_RDLEN: begin
            if (rdlen_done) begin
              if (a_emit) phase_nxt = more_a ? PH_NAME : PH_DONE;
              else phase_nxt = PH_RDATA;
            end
          end
          PH_RDATA: begin
            if (a_emit) phase_nxt = more_a ? PH_NAME : PH_DONE;
          end
          PH_DONE: phase_nxt = PH_DONE;
          default: phase_nxt = PH_HEADER;
        endcase
      end
    end
  end

  // datapath next values
  always_comb begin
    byte_offset_nxt        = byte_offset_r;
    header_shift_nxt       = header_shift_r;
    questions_left_nxt     = questions_left_r;
    answers_left_nxt       = answers_left_r;
    field_position_nxt     = field_position_r;
    label_skip_left_nxt    = label_skip_left_r;
    record_start_nxt       = record_start_r;
    tc_shift_nxt           = tc_shift_r;
    rdata_skip_left_nxt    = rdata_skip_left_r;
    rdata_start_nxt        = rdata_start_r;
    saved_rdata_length_nxt = saved_rdata_length_r;
    name_bytes_nxt         = name_bytes_r;
    if (in_fire) begin
      byte_offset_nxt = off_inc;
      case (phase_r)
        PH_HEADER: begin
          if (cur < OFS_W'(HDR_SHIFTED)) header_shift_nxt = {header_shift_r[55:0], packet_byte};
          if (hdr_emit) begin
            questions_left_nxt  = qd_clamp;
            answers_left_nxt    = an_clamp;
            field_position_nxt  = 3'd0;
            label_skip_left_nxt = 8'd0;
          end
        end
        PH_NAME: begin
          if (name_first) begin
            record_start_nxt   = cur;
            name_bytes_nxt     = 11'd1;
            field_position_nxt = 3'd1;
          end else begin
            name_bytes_nxt = name_bytes_inc;
          end
          if (!skip_zero) begin
            label_skip_left_nxt = label_skip_left_r - 8'd1;
          end else if (name_end) begin
            field_position_nxt = 3'd0;
          end else if (!name_ptr) begin
            label_skip_left_nxt = packet_byte;
          end
        end
        PH_PTR2: begin
          name_bytes_nxt     = name_bytes_inc;
          field_position_nxt = 3'd0;
        end
        PH_TYPECLASS: begin
          tc_shift_nxt       = tc_shifted;
          field_position_nxt = field_position_r + 3'd1;
          if (tc_done) begin
            field_position_nxt = 3'd0;
            if (q_emit) questions_left_nxt = questions_left_r - QCNT_W'(1);
          end
        end
        PH_TTL: begin
          tc_shift_nxt       = tc_shifted;
          field_position_nxt = ttl_done ? 3'd0 : field_position_r + 3'd1;
        end
        PH_RDLEN: begin
          saved_rdata_length_nxt = rdlen_val;
          field_position_nxt     = field_position_r + 3'd1;
          if (rdlen_done) begin
            field_position_nxt  = 3'd0;
            rdata_start_nxt     = off_inc;
            rdata_skip_left_nxt = rdlen_val;
            if (a_emit) answers_left_nxt = answers_left_r - ACNT_W'(1);
          end
        end
        PH_RDATA: begin
          rdata_skip_left_nxt = rdata_skip_left_r - 16'd1;
          if (a_emit) answers_left_nxt = answers_left_r - ACNT_W'(1);
        end
        default: ;
      endcase
      if (last_byte) begin
        byte_offset_nxt     = '0;
        questions_left_nxt  = '0;
        answers_left_nxt    = '0;
        field_position_nxt  = 3'd0;
        label_skip_left_nxt = 8'd0;
      end
    end
  end

  // result
  always_comb begin
    res       = '0;
    res_valid = 1'b0;
    if (in_fire) begin
      if (trunc) begin
        res_valid       = 1'b1;
        res.result_kind = KIND_TRUNC;
        res.name_offset = name_first ? cur : record_start_r;
      end else if (hdr_emit) begin
        res_valid          = 1'b1;
        res.result_kind    = KIND_HEADER;
        res.query_id       = {header_shift_r[55:48], header_shift_r[63:56]};
        res.header_flags   = header_shift_r[47:32];
        res.question_count = hdr_qd;
        res.answer_count   = hdr_an;
      end else if ((phase_r == PH_HEADER) && last_byte) begin
        res_valid       = 1'b1;
        res.result_kind = KIND_SHORT;
      end else if (q_emit) begin
        res_valid        = 1'b1;
        res.result_kind  = KIND_QUESTION;
        res.name_offset  = record_start_r;
        res.name_length  = name_bytes_r;
        res.record_type  = tc_shifted[31:16];
        res.record_class = tc_shifted[15:0];
      end else if (a_emit) begin
        res_valid        = 1'b1;
        res.result_kind  = KIND_ANSWER;
        res.name_offset  = record_start_r;
        res.name_length  = name_bytes_r;
        res.record_type  = tc_shift_r[63:48];
        res.record_class = tc_shift_r[47:32];
        res.time_to_live = tc_shift_r[31:0];
        res.rdata_offset = rdlen_done ? off_inc : rdata_start_r;
        res.rdata_length = rdlen_done ? rdlen_val : saved_rdata_length_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r           <= PH_HEADER;
      byte_offset_r     <= '0;
      questions_left_r  <= '0;
      answers_left_r    <= '0;
      field_position_r  <= 3'd0;
      label_skip_left_r <= 8'd0;
    end else begin
      phase_r           <= phase_nxt;
      byte_offset_r     <= byte_offset_nxt;
      questions_left_r  <= questions_left_nxt;
      answers_left_r    <= answers_left_nxt;
      field_position_r  <= field_position_nxt;
      label_skip_left_r <= label_skip_left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    header_shift_r       <= header_shift_nxt;
    record_start_r       <= record_start_nxt;
    tc_shift_r           <= tc_shift_nxt;
    rdata_skip_left_r    <= rdata_skip_left_nxt;
    rdata_start_r        <= rdata_start_nxt;
    saved_rdata_length_r <= saved_rdata_length_nxt;
    name_bytes_r         <= name_bytes_nxt;
  end

endmodule

// ===== src/dns_message_field_parser_unit.sv =====
// ----------------------------------------------------------------------------
// dns_message_field_parser_unit
// DNS packet field parser with a streaming byte input and a result output.
// ----------------------------------------------------------------------------
// The unit takes one packet byte per cycle and never stalls on its own: the
// parse state is updated by single-cycle logic for every accepted word, and a
// result (header, question, answer, short header or truncated record) is
// registered into the two-entry output buffer with the byte that completes
// it, behind any earlier result; in_tready drops only when two results wait
// behind a stalled output. No clearing pass after reset.
module dns_message_field_parser_unit import dnsmfp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,   // packet_byte
  input  logic               in_tlast,   // last_byte
  output logic               out_tvalid,
  input  logic               out_tready,
  // query_id, header_flags, question_count, answer_count, name_offset,
  // name_length, record_type, record_class, time_to_live, rdata_offset,
  // rdata_length, zero pad
  output logic [TDATA_W-1:0] out_tdata,
  output logic [2:0]         out_tuser   // result_kind
);

  logic in_fire, push, pop;
  res_t res;
  res_t head_r, skid_r;
  logic head_valid_r, skid_valid_r;

  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign pop       = head_valid_r && out_tready;

  dnsmfp_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .packet_byte (in_tdata),
    .last_byte   (in_tlast),
    .res_valid   (push),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop || !head_valid_r) begin
      if (skid_valid_r) begin
        head_valid_r <= 1'b1;
        skid_valid_r <= push;
      end else begin
        head_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !head_valid_r) begin
      if (skid_valid_r) begin
        head_r <= skid_r;
        if (push) skid_r <= res;
      end else if (push) begin
        head_r <= res;
      end
    end else if (push) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = head_valid_r;
  assign out_tuser  = head_r.result_kind;
  assign out_tdata  = {7'd0, head_r.rdata_length, head_r.rdata_offset, head_r.time_to_live,
                       head_r.record_class, head_r.record_type, head_r.name_length,
                       head_r.name_offset, head_r.answer_count, head_r.question_count,
                       head_r.header_flags, head_r.query_id};

`ifndef SYNTHESIS
  a_skid_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> head_valid_r) else $error("skid entry without head entry");

  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !pop) |=> skid_valid_r) else $error("skid entry lost");

  a_head_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !skid_valid_r && !push) |=> !head_valid_r) else $error("result repeated");

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !head_valid_r) |=> (head_valid_r && !skid_valid_r))
    else $error("result not placed in head");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !push) else $error("result produced while buffer full");
`endif

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for dns_message_field_parser_unit. Packets are built
// from header, question and answer parts and streamed one byte per word. Each
// accepted byte goes through a local parse model that queues the expected
// results. Every result word is checked field by field against that queue.
// Directed packets cover short headers, every name form, count clamping,
// cut-off points in the record phases and a long output hold. Random packets
// follow with idle cycles on both sides, then a run without idle cycles.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import dnsmfp_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 4;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [7:0]         in_tdata   = '0;
  logic               in_tlast   = 1'b0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;
  logic [2:0]         out_tuser;

  // parse model state
  phase_t      phase;
  logic [10:0] offset;
  logic [63:0] header_bits;
  int unsigned questions_todo;
  int unsigned answers_todo;
  int unsigned field_idx;
  logic [7:0]  skip_label;
  logic [10:0] record_ofs;
  logic [63:0] fixed_bits;
  logic [15:0] rdata_todo;
  logic [10:0] rdata_ofs;
  logic [15:0] rdata_len;
  logic [10:0] name_len;

  res_t       expected_records[$];
  logic [7:0] wire_bytes[$];
  int         mismatches   = 0;
  int         quiet_cycles = 0;
  bit         send_gaps    = 1'b1;
  bit         recv_gaps    = 1'b1;
  bit         hold_request = 1'b0;

  dns_message_field_parser_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic clear_parse_state();
    phase          = PH_HEADER;
    offset         = '0;
    header_bits    = '0;
    questions_todo = 0;
    answers_todo   = 0;
    field_idx      = 0;
    skip_label     = '0;
    record_ofs     = '0;
    fixed_bits     = '0;
    rdata_todo     = '0;
    rdata_ofs      = '0;
    rdata_len      = '0;
    name_len       = '0;
  endtask

  task automatic close_record();
    field_idx  = 0;
    skip_label = '0;
    phase      = (questions_todo > 0 || answers_todo > 0) ? PH_NAME : PH_DONE;
  endtask

  task automatic finish_answer(inout res_t r);
    r.result_kind  = KIND_ANSWER;
    r.name_offset  = record_ofs;
    r.name_length  = name_len;
    r.record_type  = fixed_bits[63:48];
    r.record_class = fixed_bits[47:32];
    r.time_to_live = fixed_bits[31:0];
    r.rdata_offset = rdata_ofs;
    r.rdata_length = rdata_len;
    answers_todo--;
    close_record();
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic last);
    logic [10:0] cur;
    logic        in_record;
    logic        completed;
    logic        produced;
    res_t        r;
    cur       = offset;
    in_record = 1'b0;
    completed = 1'b0;
    produced  = 1'b0;
    r         = '0;
    offset    = (cur < OFS_MAX) ? cur + 11'd1 : 11'(OFS_MAX);
    case (phase)
      PH_HEADER: begin
        if (cur < HDR_SHIFTED) header_bits = {header_bits[55:0], b};
        if (cur >= HDR_BYTES - 1) begin
          r.result_kind    = KIND_HEADER;
          r.query_id       = {header_bits[55:48], header_bits[63:56]};
          r.header_flags   = header_bits[47:32];
          r.question_count = header_bits[31:16];
          r.answer_count   = header_bits[15:0];
          questions_todo   = (header_bits[31:16] < MAX_QUESTIONS) ?
                             header_bits[31:16] : MAX_QUESTIONS;
          answers_todo     = (header_bits[15:0] < MAX_ANSWERS) ?
                             header_bits[15:0] : MAX_ANSWERS;
          close_record();
          produced = 1'b1;
        end else if (last) begin
          r.result_kind = KIND_SHORT;
          produced      = 1'b1;
        end
      end
      PH_NAME: begin
        in_record = 1'b1;
        if (field_idx == 0) begin
          field_idx  = 1;
          record_ofs = cur;
          name_len   = '0;
          skip_label = '0;
        end
        if (name_len < 11'd2047) name_len++;
        if (skip_label > 0) begin
          skip_label--;
        end else if (b == 8'h00) begin
          phase     = PH_TYPECLASS;
          field_idx = 0;
        end else if ((b & PTR_MASK) != 0) begin
          phase = PH_PTR2;
        end else begin
          skip_label = b;
        end
      end
      PH_PTR2: begin
        in_record = 1'b1;
        if (name_len < 11'd2047) name_len++;
        phase     = PH_TYPECLASS;
        field_idx = 0;
      end
      PH_TYPECLASS: begin
        in_record  = 1'b1;
        fixed_bits = {fixed_bits[55:0], b};
        field_idx++;
        if (field_idx >= TC_BYTES) begin
          field_idx = 0;
          if (questions_todo > 0) begin
            r.result_kind  = KIND_QUESTION;
            r.name_offset  = record_ofs;
            r.name_length  = name_len;
            r.record_type  = fixed_bits[31:16];
            r.record_class = fixed_bits[15:0];
            questions_todo--;
            close_record();
            completed = 1'b1;
            produced  = 1'b1;
          end else begin
            phase = PH_TTL;
          end
        end
      end
      PH_TTL: begin
        in_record  = 1'b1;
        fixed_bits = {fixed_bits[55:0], b};
        field_idx++;
        if (field_idx >= TTL_BYTES) begin
          field_idx = 0;
          phase     = PH_RDLEN;
        end
      end
      PH_RDLEN: begin
        in_record = 1'b1;
        rdata_len = {rdata_len[7:0], b};
        field_idx++;
        if (field_idx >= RDLEN_BYTES) begin
          field_idx  = 0;
          rdata_ofs  = offset;
          rdata_todo = rdata_len;
          if (rdata_todo == 0) begin
            finish_answer(r);
            completed = 1'b1;
            produced  = 1'b1;
          end else begin
            phase = PH_RDATA;
          end
        end
      end
      PH_RDATA: begin
        in_record = 1'b1;
        rdata_todo--;
        if (rdata_todo == 0) begin
          finish_answer(r);
          completed = 1'b1;
          produced  = 1'b1;
        end
      end
      default: ;
    endcase
    if (last && in_record && !completed) begin
      r             = '0;
      r.result_kind = KIND_TRUNC;
      r.name_offset = record_ofs;
      produced      = 1'b1;
    end
    if (produced) expected_records.push_back(r);
    if (last) clear_parse_state();
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) parse_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (expected_records.size() == 0) begin
          $error("unexpected result word, kind %0d", out_tuser);
          mismatches++;
        end else begin
          want = expected_records.pop_front();
          check_field("result_kind", 32'(want.result_kind), 32'(out_tuser));
          check_field("query_id", 32'(want.query_id), 32'(out_tdata[15:0]));
          check_field("header_flags", 32'(want.header_flags), 32'(out_tdata[31:16]));
          check_field("question_count", 32'(want.question_count), 32'(out_tdata[47:32]));
          check_field("answer_count", 32'(want.answer_count), 32'(out_tdata[63:48]));
          check_field("name_offset", 32'(want.name_offset), 32'(out_tdata[74:64]));
          check_field("name_length", 32'(want.name_length), 32'(out_tdata[85:75]));
          check_field("record_type", 32'(want.record_type), 32'(out_tdata[101:86]));
          check_field("record_class", 32'(want.record_class), 32'(out_tdata[117:102]));
          check_field("time_to_live", want.time_to_live, out_tdata[149:118]);
          check_field("rdata_offset", 32'(want.rdata_offset), 32'(out_tdata[160:150]));
          check_field("rdata_length", 32'(want.rdata_length), 32'(out_tdata[176:161]));
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("[FAIL] regression broken");
          $finish;
        end
      end
    end
  end

  // result side: random backpressure plus one long hold on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_tready <= !recv_gaps || ($urandom_range(99) >= 23);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while (send_gaps && $urandom_range(99) < 23) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_packet(input int len);
    for (int i = 0; i < len; i++) send_byte(wire_bytes[i], i == len - 1);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_records.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic put_word(input logic [15:0] w);
    wire_bytes.push_back(w[15:8]);
    wire_bytes.push_back(w[7:0]);
  endtask

  task automatic put_header(input logic [15:0] id, input logic [15:0] flags,
                            input logic [15:0] qd, input logic [15:0] an);
    wire_bytes.delete();
    put_word(id);
    put_word(flags);
    put_word(qd);
    put_word(an);
    repeat (4) wire_bytes.push_back(8'($urandom));
  endtask

  task automatic put_label(input int len);
    wire_bytes.push_back(8'(len));
    repeat (len) wire_bytes.push_back(8'($urandom));
  endtask

  task automatic put_pointer(input logic [1:0] tag);
    wire_bytes.push_back({tag, 6'($urandom)});
    wire_bytes.push_back(8'($urandom));
  endtask

  task automatic put_answer_tail(input logic [15:0] rtype, input logic [15:0] rclass,
                                 input logic [31:0] ttl, input logic [15:0] rdlen);
    put_word(rtype);
    put_word(rclass);
    put_word(ttl[31:16]);
    put_word(ttl[15:0]);
    put_word(rdlen);
    repeat (rdlen) wire_bytes.push_back(8'($urandom));
  endtask

  task automatic put_random_name();
    case ($urandom_range(3))
      0: wire_bytes.push_back(8'h00);
      1: put_pointer(2'($urandom_range(1, 3)));
      default: begin
        repeat ($urandom_range(1, 3)) put_label($urandom_range(1, 6));
        if ($urandom_range(1)) wire_bytes.push_back(8'h00);
        else put_pointer(2'($urandom_range(1, 3)));
      end
    endcase
  endtask

  task automatic test_short_header();
    wire_bytes.delete();
    wire_bytes.push_back(8'hff);
    send_packet(1);
    wire_bytes.delete();
    repeat (11) wire_bytes.push_back(8'h00);
    send_packet(11);
  endtask

  task automatic test_header_only();
    put_header(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_packet(HDR_BYTES);
    put_header(16'hffff, 16'hffff, 16'h0000, 16'h0000);
    repeat (3) wire_bytes.push_back(8'hff);
    send_packet(wire_bytes.size());
  endtask

  task automatic test_record_forms();
    put_header(16'hffff, 16'hffff, 16'd2, 16'd3);
    wire_bytes.push_back(8'h00);
    put_word(16'hffff);
    put_word(16'h0000);
    put_label(1);
    put_label(2);
    wire_bytes.push_back(8'h00);
    put_word(16'h0001);
    put_word(16'h0001);
    put_pointer(2'b11);
    put_answer_tail(16'h0001, 16'h0001, 32'hffff_ffff, 16'h0000);
    put_pointer(2'b01);
    put_answer_tail(16'h0005, 16'h00ff, 32'h0000_0001, 16'h0002);
    put_label(5);
    put_pointer(2'b10);
    put_answer_tail(16'h0000, 16'hffff, 32'h0000_0000, 16'h0001);
    send_packet(wire_bytes.size());
  endtask

  // one question more than the limit: the extra one is walked as an answer
  task automatic test_count_clamp();
    put_header(16'($urandom), 16'($urandom), 16'hffff, 16'hffff);
    repeat (MAX_QUESTIONS + 1) begin
      wire_bytes.push_back(8'h00);
      put_word(16'($urandom));
      put_word(16'($urandom));
    end
    send_packet(wire_bytes.size());
  endtask

  // same packet cut off inside the label, pointer, ttl and rdata
  task automatic test_truncation();
    int cuts[4];
    cuts = '{14, 20, 27, 32};
    put_header(16'($urandom), 16'($urandom), 16'd1, 16'd1);
    put_label(1);
    wire_bytes.push_back(8'h00);
    put_word(16'h001c);
    put_word(16'h0001);
    put_pointer(2'b11);
    put_answer_tail(16'h0001, 16'h0001, $urandom, 16'd2);
    repeat (2) wire_bytes.push_back(8'($urandom));
    foreach (cuts[i]) send_packet(cuts[i]);
  endtask

  task automatic test_output_hold();
    put_header(16'($urandom), 16'($urandom), 16'd8, 16'd0);
    repeat (8) begin
      wire_bytes.push_back(8'h00);
      put_word(16'($urandom));
      put_word(16'($urandom));
    end
    send_gaps    = 1'b0;
    hold_request = 1'b1;
    send_packet(wire_bytes.size());
    send_gaps    = 1'b1;
  endtask

  task automatic test_random_packets(input int byte_budget);
    int          sent;
    int          len;
    int          nq;
    int          na;
    logic [15:0] qd_field;
    logic [15:0] an_field;
    sent = 0;
    while (sent < byte_budget) begin
      if ($urandom_range(99) < 10) begin
        wire_bytes.delete();
        repeat ($urandom_range(1, 30)) wire_bytes.push_back(8'($urandom));
      end else begin
        qd_field = 16'($urandom_range(3));
        an_field = 16'($urandom_range(3));
        if ($urandom_range(9) == 0) qd_field = 16'($urandom);
        if ($urandom_range(9) == 0) an_field = 16'($urandom);
        put_header(16'($urandom), 16'($urandom), qd_field, an_field);
        nq = (qd_field < 3) ? qd_field : 3;
        na = (an_field < 3) ? an_field : 3;
        repeat (nq) begin
          put_random_name();
          put_word(16'($urandom));
          put_word(16'($urandom));
        end
        repeat (na) begin
          put_random_name();
          put_answer_tail(16'($urandom), 16'($urandom), $urandom,
                          16'($urandom_range(6)));
        end
        if ($urandom_range(99) < 15)
          repeat ($urandom_range(1, 8)) wire_bytes.push_back(8'($urandom));
      end
      len = wire_bytes.size();
      if ($urandom_range(99) < 15) len = $urandom_range(1, len);
      send_packet(len);
      sent += len;
    end
  endtask

  task automatic test_back_to_back();
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    test_random_packets(30);
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
  endtask

  initial begin
    clear_parse_state();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_short_header();
    wait_idle();
    test_header_only();
    wait_idle();
    test_record_forms();
    wait_idle();
    test_count_clamp();
    wait_idle();
    test_truncation();
    wait_idle();
    test_output_hold();
    wait_idle();
    test_random_packets(30);
    wait_idle();
    test_back_to_back();
    wait_idle();
    if (mismatches == 0 && expected_records.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
